@@ design/bta_pkg.sv @@
// Shared types, codes and constants of the boundary-tag best-fit allocator.
// Used by the tag memory, the sequencer, the top level and the checker.
package bta_pkg;

   // Arithmetic width: holds any 32-bit signed tag plus a pool address without overflow.
   localparam int ExtW = 34;
   localparam int TagW = 32;
   localparam int OffW = 12;

   typedef logic signed [ExtW-1:0] ext_type;
   typedef logic [TagW-1:0]        tag_type;
   typedef logic [OffW-1:0]        off_type;

   // Bytes in one header or footer, and the framing overhead of one block.
   localparam ext_type TagBytes   = ext_type'(4);
   localparam ext_type FrameBytes = ext_type'(8);

   typedef enum logic [0:0] {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } kind_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_INIT_HDR,
      ST_INIT_FTR,
      ST_IDLE,
      ST_WALK,
      ST_A_W0,
      ST_A_W1,
      ST_A_W2,
      ST_A_W3,
      ST_F_SIZE,
      ST_F_LEFT_TAG,
      ST_F_W0,
      ST_F_W1,
      ST_F_RIGHT,
      ST_F_M0,
      ST_F_M1,
      ST_F_M2,
      ST_F_M3,
      ST_F_LEFT,
      ST_F_H1,
      ST_F_J0,
      ST_F_J1,
      ST_F_J2,
      ST_F_J3,
      ST_DONE
   } state_type;

   // Tag memory operation: a read, a tag write or a row fill with zeros; a read can go with a write.
   typedef struct packed {
      logic    rd_en;
      ext_type rd_addr;
      logic    wr_en;
      logic    fill_en;
      ext_type wr_addr;
      tag_type wr_data;
   } mem_op_type;

   typedef struct packed {
      logic     start;
      kind_type kind;
      off_type  size;
      off_type  offset;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      logic    success;
      off_type offset;
   } result_type;

endpackage

@@ design/bta_tagmem.sv @@
// Byte pool stored as four byte-lane memories with unaligned 32-bit tag access.
// Depends on bta_pkg for the access and tag types.
module bta_tagmem #(
   parameter int POOL_BYTES = 4096
) (
   input  logic                clock,
   input  bta_pkg::mem_op_type mem_op,
   output bta_pkg::tag_type    rd_data
);
   import bta_pkg::*;

   localparam int Depth = (POOL_BYTES + 3) / 4;
   localparam int RW    = (Depth > 1) ? $clog2(Depth) : 1;
   localparam ext_type PoolExt = ext_type'(POOL_BYTES);

   logic       rd_in_pool;
   logic       wr_in_pool;
   logic       oob_ff;
   logic [1:0] sh_ff;
   logic [7:0] bank_q [4];

   // A tag lies in the pool when all four of its bytes do.
   assign rd_in_pool = (mem_op.rd_addr >= 0) && (mem_op.rd_addr + TagBytes <= PoolExt);
   assign wr_in_pool = (mem_op.wr_addr >= 0) && (mem_op.wr_addr + TagBytes <= PoolExt);

   // Each lane serves the one byte of the tag that falls into it.
   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [7:0]    mem_ff [Depth];
      logic [7:0]    q_ff;
      logic [1:0]    rk;
      logic [1:0]    wk;
      ext_type       rsum;
      ext_type       wsum;
      logic [RW-1:0] rrow;
      logic [RW-1:0] wrow;
      logic [7:0]    wbyte;

      always_comb begin
         rk    = 2'(b) - mem_op.rd_addr[1:0];
         wk    = 2'(b) - mem_op.wr_addr[1:0];
         rsum  = mem_op.rd_addr + ext_type'(rk);
         wsum  = mem_op.wr_addr + ext_type'(wk);
         rrow  = rsum[RW+1:2];
         wrow  = mem_op.fill_en ? mem_op.wr_addr[RW+1:2] : wsum[RW+1:2];
         wbyte = mem_op.fill_en ? 8'h00 : mem_op.wr_data[8*wk +: 8];
      end

      always_ff @(posedge clock) begin
         if (mem_op.fill_en || (mem_op.wr_en && wr_in_pool)) begin
            mem_ff[wrow] <= wbyte;
         end
         if (mem_op.rd_en && rd_in_pool) begin
            q_ff <= mem_ff[rrow];
         end
      end

      assign bank_q[b] = q_ff;
   end

   // Remember the alignment and range of the pending read.
   always_ff @(posedge clock) begin
      if (mem_op.rd_en) begin
         oob_ff <= !rd_in_pool;
         sh_ff  <= mem_op.rd_addr[1:0];
      end
   end

   // Rotate the lanes back into tag byte order; tags outside the pool read as zero.
   always_comb begin
      logic [1:0] idx;
      rd_data = '0;
      for (int i = 0; i < 4; i++) begin
         idx = sh_ff + 2'(i);
         rd_data[8*i +: 8] = bank_q[idx];
      end
      if (oob_ff) begin
         rd_data = '0;
      end
   end

endmodule

@@ design/bta_ctrl.sv @@
// Sequencer of the allocator: clearing pass, best-fit walk, split and coalescing.
// Depends on bta_pkg; drives the reads and writes of the tag memory.
module bta_ctrl #(
   parameter int POOL_BYTES = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  bta_pkg::cmd_type    cmd,
   output logic                idle,
   output bta_pkg::result_type res,
   input  logic                res_take,
   output bta_pkg::mem_op_type mem_op,
   input  bta_pkg::tag_type    rd_data
);
   import bta_pkg::*;

   localparam int Depth = (POOL_BYTES + 3) / 4;
   localparam int RW    = (Depth > 1) ? $clog2(Depth) : 1;
   localparam ext_type PoolExt = ext_type'(POOL_BYTES);

   state_type     state_ff, state_in;
   logic [RW-1:0] clr_ff, clr_in;
   off_type       size_ff, size_in;
   ext_type       it_ff, it_in;
   ext_type       best_ff, best_in;
   ext_type       besth_ff, besth_in;
   ext_type       closest_ff, closest_in;
   logic          found_ff, found_in;
   ext_type       p_ff, p_in;
   ext_type       s_ff, s_in;
   ext_type       f_ff, f_in;
   ext_type       cur_ff, cur_in;
   tag_type       val_ff, val_in;
   ext_type       lft_ff, lft_in;
   logic          succ_ff, succ_in;
   off_type       off_ff, off_in;

   ext_type h_e;
   ext_type h_mag;
   ext_type size_e;
   ext_type nxt;
   ext_type right;
   ext_type lft;
   logic    cand;

   // Tag just read, as a signed value and as a magnitude.
   assign h_e    = ext_type'($signed(rd_data));
   assign h_mag  = (h_e < 0) ? -h_e : h_e;
   assign size_e = ext_type'(size_ff);
   assign nxt    = it_ff + h_mag + FrameBytes;
   assign right  = p_ff + s_ff + FrameBytes;
   assign lft    = p_ff - FrameBytes - f_ff;
   assign cand   = (h_e > size_e + FrameBytes) && (it_ff + h_e + FrameBytes <= PoolExt) &&
                   (h_e - size_e < closest_ff);

   // State register and control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      size_ff    <= size_in;
      it_ff      <= it_in;
      best_ff    <= best_in;
      besth_ff   <= besth_in;
      closest_ff <= closest_in;
      found_ff   <= found_in;
      p_ff       <= p_in;
      s_ff       <= s_in;
      f_ff       <= f_in;
      cur_ff     <= cur_in;
      val_ff     <= val_in;
      lft_ff     <= lft_in;
      succ_ff    <= succ_in;
      off_ff     <= off_in;
   end

   // Next state, memory access and result.
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      size_in    = size_ff;
      it_in      = it_ff;
      best_in    = best_ff;
      besth_in   = besth_ff;
      closest_in = closest_ff;
      found_in   = found_ff;
      p_in       = p_ff;
      s_in       = s_ff;
      f_in       = f_ff;
      cur_in     = cur_ff;
      val_in     = val_ff;
      lft_in     = lft_ff;
      succ_in    = succ_ff;
      off_in     = off_ff;
      mem_op     = '0;
      res        = '0;
      idle       = 1'b0;

      case (state_ff)
         // Zero one row per cycle, then lay down the single free block.
         ST_CLEAR: begin
            mem_op.fill_en = 1'b1;
            mem_op.wr_addr = ext_type'({clr_ff, 2'b00});
            clr_in         = clr_ff + 1'b1;
            if (clr_ff == RW'(Depth - 1)) begin
               state_in = ST_INIT_HDR;
            end
         end
         ST_INIT_HDR: begin
            mem_op.wr_en   = 1'b1;
            mem_op.wr_addr = '0;
            mem_op.wr_data = tag_type'(PoolExt - FrameBytes);
            state_in       = ST_INIT_FTR;
         end
         ST_INIT_FTR: begin
            mem_op.wr_en   = 1'b1;
            mem_op.wr_addr = PoolExt - TagBytes;
            mem_op.wr_data = tag_type'(PoolExt - FrameBytes);
            state_in       = ST_IDLE;
         end

         // Take a request and, unless it is refused at once, issue its first tag read.
         ST_IDLE: begin
            idle = 1'b1;
            if (cmd.start) begin
               size_in = cmd.size;
               p_in    = ext_type'(cmd.offset) - TagBytes;
               if (cmd.kind == REQ_ALLOC) begin
                  if (cmd.size == '0) begin
                     succ_in  = 1'b0;
                     off_in   = '0;
                     state_in = ST_DONE;
                  end else begin
                     mem_op.rd_en   = 1'b1;
                     mem_op.rd_addr = '0;
                     it_in          = '0;
                     closest_in     = PoolExt;
                     found_in       = 1'b0;
                     state_in       = ST_WALK;
                  end
               end else begin
                  if (ext_type'(cmd.offset) < TagBytes) begin
                     succ_in  = 1'b0;
                     off_in   = '0;
                     state_in = ST_DONE;
                  end else begin
                     mem_op.rd_en   = 1'b1;
                     mem_op.rd_addr = ext_type'(cmd.offset) - TagBytes;
                     state_in       = ST_F_SIZE;
                  end
               end
            end
         end

         // One header per cycle: score it and read the next one, if any.
         ST_WALK: begin
            if (cand) begin
               closest_in = h_e - size_e;
               best_in    = it_ff;
               besth_in   = h_e;
               found_in   = 1'b1;
            end
            if (nxt < PoolExt) begin
               mem_op.rd_en   = 1'b1;
               mem_op.rd_addr = nxt;
               it_in          = nxt;
            end else if (found_ff || cand) begin
               state_in = ST_A_W0;
            end else begin
               succ_in  = 1'b0;
               off_in   = '0;
               state_in = ST_DONE;
            end
         end

         // Split: used front block, free remainder.
         ST_A_W0: begin
            mem_op.wr_en   = 1'b1;
            mem_op.wr_addr = best_ff;
            mem_op.wr_data = tag_type'(-size_e);
            state_in       = ST_A_W1;
         end
         ST_A_W1: begin
            mem_op.wr_en   = 1'b1;
            mem_op.wr_addr = best_ff + size_e + TagBytes;
            mem_op.wr_data = tag_type'(-size_e);
            state_in       = ST_A_W2;
         end
         ST_A_W2: begin
            mem_op.wr_en   = 1'b1;
            mem_op.wr_addr = best_ff + size_e + FrameBytes;
            mem_op.wr_data = tag_type'(besth_ff - FrameBytes - size_e);
            state_in       = ST_A_W3;
         end
         ST_A_W3: begin
            mem_op.wr_en   = 1'b1;
            mem_op.wr_addr = best_ff + besth_ff + TagBytes;
            mem_op.wr_data = tag_type'(besth_ff - FrameBytes - size_e);
            succ_in        = 1'b1;
            off_in         = off_type'(best_ff + TagBytes);
            state_in       = ST_DONE;
         end

         // Free: check the block, fetch left footer, mark it free, read right header.
         ST_F_SIZE: begin
            if (p_ff + h_mag + FrameBytes > PoolExt) begin
               succ_in  = 1'b0;
               off_in   = '0;
               state_in = ST_DONE;
            end else begin
               s_in   = h_mag;
               cur_in = h_mag;
               if (p_ff >= TagBytes) begin
                  mem_op.rd_en   = 1'b1;
                  mem_op.rd_addr = p_ff - TagBytes;
                  state_in       = ST_F_LEFT_TAG;
               end else begin
                  f_in     = '0;
                  state_in = ST_F_W0;
               end
            end
         end
         ST_F_LEFT_TAG: begin
            f_in     = h_e;
            state_in = ST_F_W0;
         end
         ST_F_W0: begin
            mem_op.wr_en   = 1'b1;
            mem_op.wr_addr = p_ff;
            mem_op.wr_data = tag_type'(s_ff);
            state_in       = ST_F_W1;
         end
         ST_F_W1: begin
            mem_op.wr_en   = 1'b1;
            mem_op.wr_addr = p_ff + s_ff + TagBytes;
            mem_op.wr_data = tag_type'(s_ff);
            if (right + TagBytes <= PoolExt) begin
               mem_op.rd_en   = 1'b1;
               mem_op.rd_addr = right;
               state_in       = ST_F_RIGHT;
            end else begin
               state_in = ST_F_LEFT;
            end
         end

         // Merge with a free right neighbor.
         ST_F_RIGHT: begin
            if ((h_e > 0) && (right + h_e + FrameBytes <= PoolExt)) begin
               cur_in   = s_ff + h_e + FrameBytes;
               state_in = ST_F_M0;
            end else begin
               state_in = ST_F_LEFT;
            end
         end
         ST_F_M0: begin
            mem_op.wr_en   = 1'b1;
            mem_op.wr_addr = p_ff;
            mem_op.wr_data = tag_type'(cur_ff);
            state_in       = ST_F_M1;
         end
         ST_F_M1: begin
            mem_op.wr_en   = 1'b1;
            mem_op.wr_addr = p_ff + cur_ff + TagBytes;
            mem_op.wr_data = tag_type'(cur_ff);
            state_in       = ST_F_M2;
         end
         ST_F_M2: begin
            mem_op.wr_en   = 1'b1;
            mem_op.wr_addr = p_ff + s_ff + TagBytes;
            mem_op.wr_data = '0;
            state_in       = ST_F_M3;
         end
         ST_F_M3: begin
            mem_op.wr_en   = 1'b1;
            mem_op.wr_addr = right;
            mem_op.wr_data = '0;
            state_in       = ST_F_LEFT;
         end

         // Merge with a free left neighbor.
         ST_F_LEFT: begin
            if ((p_ff >= TagBytes) && (f_ff > 0) && (lft >= 0)) begin
               mem_op.rd_en   = 1'b1;
               mem_op.rd_addr = lft;
               lft_in         = lft;
               state_in       = ST_F_H1;
            end else begin
               succ_in  = 1'b1;
               off_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_F_H1: begin
            val_in   = rd_data + tag_type'(cur_ff) + tag_type'(FrameBytes);
            state_in = ST_F_J0;
         end
         ST_F_J0: begin
            mem_op.wr_en   = 1'b1;
            mem_op.wr_addr = lft_ff;
            mem_op.wr_data = val_ff;
            state_in       = ST_F_J1;
         end
         ST_F_J1: begin
            mem_op.wr_en   = 1'b1;
            mem_op.wr_addr = p_ff + cur_ff + TagBytes;
            mem_op.wr_data = val_ff;
            state_in       = ST_F_J2;
         end
         ST_F_J2: begin
            mem_op.wr_en   = 1'b1;
            mem_op.wr_addr = p_ff;
            mem_op.wr_data = '0;
            state_in       = ST_F_J3;
         end
         ST_F_J3: begin
            mem_op.wr_en   = 1'b1;
            mem_op.wr_addr = p_ff - TagBytes;
            mem_op.wr_data = '0;
            succ_in        = 1'b1;
            off_in         = '0;
            state_in       = ST_DONE;
         end

         // Hold the result until the output register can take it.
         ST_DONE: begin
            res.valid   = 1'b1;
            res.success = succ_ff;
            res.offset  = off_ff;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ design/boundary_tag_best_fit_allocator.sv @@
// Allocate: a best-fit walk over the block headers, then the tag writes of the split; the
// walk issues one tag read per cycle.
// Free: tag reads and writes for coalescing with free neighbors; a zero-size allocate
// or a free offset below 4 is refused without any tag access. One request at a time; a new request is taken
// while the previous result waits in the output register.
// Reset (synchronous): requests stall through a clearing pass.
module boundary_tag_best_fit_allocator #(
   parameter int POOL_BYTES = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_type,
   input  bta_pkg::off_type req_alloc_size,
   input  bta_pkg::off_type req_free_offset,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_success,
   output bta_pkg::off_type rsp_payload_offset
);
   import bta_pkg::*;

   cmd_type    cmd;
   result_type res;
   mem_op_type mem_op;
   tag_type    rd_data;
   logic       idle;
   logic       res_take;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_success_ff;
   off_type    rsp_offset_ff;

   // A request transfers whenever the sequencer is idle.
   assign req_stall  = !idle;
   assign cmd.start  = req_valid && idle;
   assign cmd.kind   = kind_type'(req_type);
   assign cmd.size   = req_alloc_size;
   assign cmd.offset = req_free_offset;

   // The output register takes a new result when empty or being drained.
   assign res_take     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = (res.valid && res_take) ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid && res_take) begin
         rsp_success_ff <= res.success;
         rsp_offset_ff  <= res.offset;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_success        = rsp_success_ff;
   assign rsp_payload_offset = rsp_offset_ff;

   bta_ctrl #(
      .POOL_BYTES(POOL_BYTES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .idle     (idle),
      .res      (res),
      .res_take (res_take),
      .mem_op   (mem_op),
      .rd_data  (rd_data)
   );

   bta_tagmem #(
      .POOL_BYTES(POOL_BYTES)
   ) u_mem (
      .clock   (clock),
      .mem_op  (mem_op),
      .rd_data (rd_data)
   );

endmodule

@@ design/bta_checker.sv @@
// Port-level checks of the allocator's handshakes and results over time.
// Depends on bta_pkg; bound to the top level at the end of this file.
module bta_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic             rsp_success,
   input bta_pkg::off_type rsp_payload_offset
);

   // A stalled result holds until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_success) &&
                                 $stable(rsp_payload_offset))
      else $error("stalled result changed");

   // A refused request never reports an offset.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_success |-> rsp_payload_offset == '0)
      else $error("failed request carries an offset");

   // Requests are served one at a time.
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

   // The clearing pass blocks requests right after reset.
   a_reset_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request accepted during clearing pass");

endmodule

bind boundary_tag_best_fit_allocator bta_checker u_bta_checker (.*);
